>>> sv/probe_slot_allocator_defines.svh
// Assertion macros shared by the probe slot allocator RTL.
`ifndef PROBE_SLOT_ALLOCATOR_DEFINES_SVH
`define PROBE_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/psa_pkg.sv
// Shared widths, defaults, status codes and control structs of the probe slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;

  localparam int ADDR_W     = 64;
  localparam int PROG_W     = 32;
  localparam int SLOT_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 13;
  localparam int POS_W      = 14;
  localparam int SLOT_DEPTH = 4096;
  localparam int SLOT_MAX   = 4095;

  localparam int DEF_SLOTS_PER_PAGE = 256;
  localparam int DEF_HEADER_SLOTS   = 1;
  localparam int DEF_MAX_PAGES      = 16;

  localparam logic [PROG_W-1:0] NOOP_RESET = '1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_ERASED   = 3'd1,
    STAT_IGNORED  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic commit;
  } psa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } psa_sts_t;

endpackage
`default_nettype wire

>>> sv/psa_in_if.sv
// Update channel: valid/ready handshake with the update payload.
`timescale 1ns / 1ps
`default_nettype none
interface psa_in_if import psa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] target_address;
  logic [SLOT_W-1:0] slot_index;
  logic [PROG_W-1:0] entry_program;
  logic [PROG_W-1:0] return_program;

  modport source (output valid, output target_address, output slot_index,
                  output entry_program, output return_program, input ready);
  modport sink   (input valid, input target_address, input slot_index,
                  input entry_program, input return_program, output ready);
endinterface
`default_nettype wire

>>> sv/psa_out_if.sv
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
`default_nettype none
interface psa_out_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  logic                probe_attached;
  logic                probe_released;
  logic [SLOT_W-1:0]   high_water;
  logic [SLOT_W-1:0]   active_count;

  modport source (output valid, output slot_out, output status, output probe_attached,
                  output probe_released, output high_water, output active_count,
                  input ready);
  modport sink   (input valid, input slot_out, input status, input probe_attached,
                  input probe_released, input high_water, input active_count,
                  output ready);
endinterface
`default_nettype wire

>>> sv/psa_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/psa_ctrl.sv
// Sequencer: clearing pass after reset, then accept / execute per transaction.
`timescale 1ns / 1ps
`default_nettype none
module psa_ctrl import psa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire psa_sts_t sts,
  output psa_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_blocked) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.clear_wr = (state_r == ST_CLEAR);
  assign cmd.accept   = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit   = (state_r == ST_EXEC) && !sts.out_blocked;

endmodule
`default_nettype wire

>>> sv/psa_dp.sv
// Datapath: slot store, freed-slot stack, page/fresh-slot counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module psa_dp import psa_pkg::*; #(
  parameter int SLOTS_PER_PAGE = DEF_SLOTS_PER_PAGE,
  parameter int HEADER_SLOTS   = DEF_HEADER_SLOTS,
  parameter int MAX_PAGES      = DEF_MAX_PAGES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psa_cmd_t            cmd,
  output psa_sts_t                 sts,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [PROG_W-1:0]   cfg_wdata,
  // update payload
  input  wire logic [ADDR_W-1:0]   in_target_address,
  input  wire logic [SLOT_W-1:0]   in_slot_index,
  input  wire logic [PROG_W-1:0]   in_entry_program,
  input  wire logic [PROG_W-1:0]   in_return_program,
  // result
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SLOT_W-1:0]        out_slot_out,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_probe_attached,
  output logic                     out_probe_released,
  output logic [SLOT_W-1:0]        out_high_water,
  output logic [SLOT_W-1:0]        out_active_count
);

  // capacity and page geometry, all resolved at elaboration
  localparam int TOTAL  = MAX_PAGES * SLOTS_PER_PAGE;
  localparam int CAP    = (TOTAL <= HEADER_SLOTS) ? 0 :
                          ((TOTAL - HEADER_SLOTS > SLOT_MAX) ? SLOT_MAX
                                                              : TOTAL - HEADER_SLOTS);
  localparam int TOP    = HEADER_SLOTS + CAP;
  localparam int TOP_M1 = (TOP > 0) ? TOP - 1 : 0;
  localparam int PFIRST = HEADER_SLOTS / SLOTS_PER_PAGE;
  localparam int PLAST  = (CAP == 0) ? 0 : TOP_M1 / SLOTS_PER_PAGE;
  localparam bit HAS_FRESH = (CAP > 0);
  localparam int PG_W   = $clog2(MAX_PAGES + 1);

  // page 0 as set up by reset
  localparam bit RST_OPEN = HAS_FRESH && (PFIRST == 0);
  localparam int RST_HI   = (SLOTS_PER_PAGE - 1 < TOP_M1) ? SLOTS_PER_PAGE - 1 : TOP_M1;
  localparam int RST_LEFT = RST_OPEN ? RST_HI - HEADER_SLOTS + 1 : 0;
  localparam int RST_NEXT = RST_OPEN ? RST_HI - HEADER_SLOTS : 0;

  localparam int MEM_W = ADDR_W + 1;

  // control state
  logic [PROG_W-1:0]  noop_r;
  logic [COUNT_W-1:0] freed_count_r, freed_count_nxt;
  logic [PG_W-1:0]    pages_open_r, pages_open_nxt;
  logic [COUNT_W-1:0] fresh_left_r, fresh_left_nxt;
  logic [SLOT_W-1:0]  fresh_next_r, fresh_next_nxt;
  logic [COUNT_W-1:0] high_mark_r, high_mark_nxt;
  logic [COUNT_W-1:0] live_count_r, live_count_nxt;
  logic [SLOT_W-1:0]  clr_r;
  logic               out_valid_r, out_valid_nxt;

  // captured transaction
  logic               is_erase_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [SLOT_W-1:0]  idx_r;
  logic               att_r;

  // result register
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_att_r, res_att_nxt;
  logic                res_rel_r, res_rel_nxt;

  // memory ports
  logic [MEM_W-1:0]  slot_q, slot_wdata;
  logic [SLOT_W-1:0] slot_waddr, stack_q, stack_raddr;
  logic              slot_we, stack_we;

  // page opening
  logic              open_req;
  logic [PG_W-1:0]   p_sel;
  logic [POS_W-1:0]  base, lo, hi, hi_cand;

  // execute decisions
  logic              in_range, active, erase_do, use_freed, use_fresh, insert_do;
  logic [SLOT_W-1:0] alloc_slot;

  // next fresh page, taken at accept when the current page is used up
  assign open_req = cmd.accept && (in_target_address != '0) && (freed_count_r == '0) &&
                    (fresh_left_r == '0) && (pages_open_r < PG_W'(MAX_PAGES));
  assign p_sel    = (pages_open_r < PG_W'(PFIRST)) ? PG_W'(PFIRST) : pages_open_r;
  assign base     = POS_W'(p_sel) * POS_W'(SLOTS_PER_PAGE);
  assign hi_cand  = base + POS_W'(SLOTS_PER_PAGE - 1);
  assign lo       = (base < POS_W'(HEADER_SLOTS)) ? POS_W'(HEADER_SLOTS) : base;
  assign hi       = (hi_cand < POS_W'(TOP_M1)) ? hi_cand : POS_W'(TOP_M1);

  // execute-cycle decisions on the read data
  assign in_range   = {1'b0, idx_r} < COUNT_W'(CAP);
  assign active     = slot_q[ADDR_W-1:0] != '0;
  assign erase_do   = is_erase_r && in_range && active;
  assign use_freed  = freed_count_r != '0;
  assign use_fresh  = !use_freed && (fresh_left_r != '0);
  assign alloc_slot = use_freed ? stack_q : fresh_next_r;
  assign insert_do  = !is_erase_r && (use_freed || use_fresh);

  always_comb begin
    freed_count_nxt = freed_count_r;
    pages_open_nxt  = pages_open_r;
    fresh_left_nxt  = fresh_left_r;
    fresh_next_nxt  = fresh_next_r;
    high_mark_nxt   = high_mark_r;
    live_count_nxt  = live_count_r;
    res_slot_nxt    = res_slot_r;
    res_status_nxt  = res_status_r;
    res_att_nxt     = res_att_r;
    res_rel_nxt     = res_rel_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    // open a page (skipping empty ones) at accept
    if (open_req) begin
      if (HAS_FRESH && (pages_open_r <= PG_W'(PLAST))) begin
        pages_open_nxt = p_sel + PG_W'(1);
        fresh_left_nxt = COUNT_W'(hi - lo + POS_W'(1));
        fresh_next_nxt = SLOT_W'(hi - POS_W'(HEADER_SLOTS));
      end else begin
        pages_open_nxt = PG_W'(MAX_PAGES);
        fresh_left_nxt = '0;
        fresh_next_nxt = '0;
      end
    end

    // commit the transaction and load the result
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      res_att_nxt   = 1'b0;
      res_rel_nxt   = 1'b0;
      if (is_erase_r) begin
        res_slot_nxt = idx_r;
        if (!in_range) begin
          res_status_nxt = STAT_RANGE;
        end else if (!active) begin
          res_status_nxt = STAT_IGNORED;
        end else begin
          res_status_nxt  = STAT_ERASED;
          res_rel_nxt     = slot_q[ADDR_W];
          freed_count_nxt = freed_count_r + COUNT_W'(1);
          if (live_count_r != '0) live_count_nxt = live_count_r - COUNT_W'(1);
        end
      end else if (insert_do) begin
        res_slot_nxt   = alloc_slot;
        res_status_nxt = STAT_INSERTED;
        res_att_nxt    = att_r;
        live_count_nxt = live_count_r + COUNT_W'(1);
        if ({1'b0, alloc_slot} + COUNT_W'(1) > high_mark_r) begin
          high_mark_nxt = {1'b0, alloc_slot} + COUNT_W'(1);
        end
        if (use_freed) begin
          freed_count_nxt = freed_count_r - COUNT_W'(1);
        end else begin
          fresh_left_nxt = fresh_left_r - COUNT_W'(1);
          if (fresh_next_r != '0) fresh_next_nxt = fresh_next_r - SLOT_W'(1);
        end
      end else begin
        res_slot_nxt   = '0;
        res_status_nxt = STAT_FULL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noop_r        <= NOOP_RESET;
      freed_count_r <= '0;
      pages_open_r  <= PG_W'(1);
      fresh_left_r  <= COUNT_W'(RST_LEFT);
      fresh_next_r  <= SLOT_W'(RST_NEXT);
      high_mark_r   <= '0;
      live_count_r  <= '0;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) noop_r <= cfg_wdata;
      freed_count_r <= freed_count_nxt;
      pages_open_r  <= pages_open_nxt;
      fresh_left_r  <= fresh_left_nxt;
      fresh_next_r  <= fresh_next_nxt;
      high_mark_r   <= high_mark_nxt;
      live_count_r  <= live_count_nxt;
      if (cmd.clear_wr) clr_r <= clr_r + SLOT_W'(1);
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_erase_r <= (in_target_address == '0);
      addr_r     <= in_target_address;
      idx_r      <= in_slot_index;
      att_r      <= (in_entry_program != noop_r) || (in_return_program != noop_r);
    end
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_att_r    <= res_att_nxt;
    res_rel_r    <= res_rel_nxt;
  end

  // slot store: {probe mark, address}; cleared by a sweep after reset
  assign slot_we    = cmd.clear_wr || (cmd.commit && (erase_do || insert_do));
  assign slot_waddr = cmd.clear_wr ? clr_r : (is_erase_r ? idx_r : alloc_slot);
  assign slot_wdata = (cmd.clear_wr || is_erase_r) ? '0 : {att_r, addr_r};

  psa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_mem (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.accept),
    .raddr (in_slot_index),
    .rdata (slot_q)
  );

  // freed-slot stack: push on erase, pop (top read at accept) on insert
  assign stack_we    = cmd.commit && erase_do;
  assign stack_raddr = SLOT_W'(freed_count_r - COUNT_W'(1));

  psa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_DEPTH)
  ) u_freed_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (freed_count_r[SLOT_W-1:0]),
    .wdata (idx_r),
    .re    (cmd.accept),
    .raddr (stack_raddr),
    .rdata (stack_q)
  );

  // status to the controller
  assign sts.clear_last  = (clr_r == SLOT_W'(SLOT_MAX));
  assign sts.out_blocked = out_valid_r && !out_ready;

  // result outputs
  assign out_valid          = out_valid_r;
  assign out_slot_out       = res_slot_r;
  assign out_status         = res_status_r;
  assign out_probe_attached = res_att_r;
  assign out_probe_released = res_rel_r;
  assign out_high_water     = high_mark_r[SLOT_W-1:0];
  assign out_active_count   = live_count_r[SLOT_W-1:0];

endmodule
`default_nettype wire

>>> sv/probe_slot_allocator.sv
// Top level of the probe slot allocator: sequencer, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "probe_slot_allocator_defines.svh"

// Probe slot allocator. Each update transaction either inserts a nonzero target
// address (taking the most recently freed slot, else the next fresh slot counting
// down through the current page, opening new pages up to MAX_PAGES) or, with a
// zero address, erases slot_index. Every transaction yields exactly one result,
// which also reports the high-water mark and the active count after it.
// Timing: after reset the slot store is swept to zero, one entry per cycle, so
// the block accepts no update until the sweep is done. After that, accepting an
// update in the idle state reads the slot store and the top of the freed stack
// (both registered reads); the execute state then decides and writes back, and
// a stalled result holds the execute state until the result register is free.
// The noop descriptor may only be written while no transaction is in flight.
module probe_slot_allocator import psa_pkg::*; #(
  parameter int SLOTS_PER_PAGE = DEF_SLOTS_PER_PAGE,
  parameter int HEADER_SLOTS   = DEF_HEADER_SLOTS,
  parameter int MAX_PAGES      = DEF_MAX_PAGES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  psa_in_if.sink                 in_ch,
  psa_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [PROG_W-1:0] cfg_wdata
);

  psa_cmd_t cmd;
  psa_sts_t sts;

  psa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psa_dp #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .HEADER_SLOTS   (HEADER_SLOTS),
    .MAX_PAGES      (MAX_PAGES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_target_address  (in_ch.target_address),
    .in_slot_index      (in_ch.slot_index),
    .in_entry_program   (in_ch.entry_program),
    .in_return_program  (in_ch.return_program),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_slot_out       (out_ch.slot_out),
    .out_status         (out_ch.status),
    .out_probe_attached (out_ch.probe_attached),
    .out_probe_released (out_ch.probe_released),
    .out_high_water     (out_ch.high_water),
    .out_active_count   (out_ch.active_count)
  );

  // checks
  `PSA_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_ch.valid, "commit without result")
  `PSA_ASSERT_NEXT(a_commit_reopens, clk, rst_n, cmd.commit, in_ch.ready, "not ready after commit")
  `PSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd.accept, !in_ch.ready, "ready while busy")
  `PSA_ASSERT_NOW(a_active_le_high, clk, rst_n, out_ch.valid, out_ch.active_count <= out_ch.high_water, "active count above high water")

endmodule
`default_nettype wire
